[rtl/core/emgfc_pkg.sv]
// Shared constants, command codes and types for the EMG filter chain.
package emgfc_pkg;

   localparam int SAMPLE_BITS    = 16;
   localparam int CENT_W         = SAMPLE_BITS + 1;
   localparam int TIME_W         = 32;
   localparam int WINDOW         = 500;
   localparam int COEF_FRAC_BITS = 28;
   localparam int COEF_W         = 32;
   localparam int SIG_FRAC       = 8;
   localparam int SIG_W          = 29;
   localparam int MUL_W          = COEF_W + SIG_W;
   localparam int ACC_W          = MUL_W + 3;
   localparam int NSTAGES        = 3;
   localparam int NTAPS          = 5;
   localparam int NHIST          = NSTAGES * 4;
   localparam int NCOEF          = NSTAGES * NTAPS;
   localparam int STAGE_W        = 2;
   localparam int STEP_W         = 3;
   localparam int IDX_W          = 4;
   localparam int PTR_W          = $clog2(WINDOW);
   localparam int CNT_W          = $clog2(WINDOW + 1);
   localparam int SQ_W           = 2 * SAMPLE_BITS;
   localparam int ROOT_W         = (SQ_W + CNT_W + 1) / 2;
   localparam int SUM_W          = 2 * ROOT_W;
   localparam int SREM_W         = ROOT_W + 3;
   localparam int ITER_W         = $clog2(SUM_W);

   localparam logic [3:0] OP_NONE  = 4'd0;
   localparam logic [3:0] OP_LOAD  = 4'd1;
   localparam logic [3:0] OP_MAC   = 4'd2;
   localparam logic [3:0] OP_STAGE = 4'd3;
   localparam logic [3:0] OP_FILT  = 4'd4;
   localparam logic [3:0] OP_SQN   = 4'd5;
   localparam logic [3:0] OP_UPD   = 4'd6;
   localparam logic [3:0] OP_DIV   = 4'd7;
   localparam logic [3:0] OP_SQRT  = 4'd8;
   localparam logic [3:0] OP_OUT   = 4'd9;

   typedef struct packed {
      logic [3:0]         op;
      logic [STAGE_W-1:0] stage;
      logic [STEP_W-1:0]  step;
   } cmd_type;

   // Rounds a seven-decimal coefficient to the Q format, ties away from zero.
   function automatic logic signed [COEF_W-1:0] coef_q(longint v);
      longint mag;
      longint q;
      mag = (v < 0) ? -v : v;
      q = (mag * (longint'(1) <<< COEF_FRAC_BITS) + 64'sd5000000) / 64'sd10000000;
      return COEF_W'((v < 0) ? -q : q);
   endfunction

   // b0, b1, b2, a1, a2 for each stage; the last entry is padding.
   localparam logic signed [COEF_W-1:0] COEF_TABLE [16] = '{
      coef_q(64'sd9149691),  coef_q(-64'sd18299383), coef_q(64'sd9149691),
      coef_q(-64'sd18226949), coef_q(64'sd8371817),
      coef_q(64'sd8005924),  coef_q(64'sd16011848),  coef_q(64'sd8005924),
      coef_q(64'sd15610181), coef_q(64'sd6413515),
      coef_q(64'sd9947912),  coef_q(-64'sd18922054), coef_q(64'sd9947912),
      coef_q(-64'sd18922054), coef_q(64'sd9895825),
      '0
   };

endpackage

[rtl/core/emgfc_intf.sv]
// Channel interfaces for sample requests, results and the offset register.
interface emgfc_req_if;
   logic                                       valid;
   logic                                       ready;
   logic signed [emgfc_pkg::SAMPLE_BITS-1:0]   raw_sample;
   logic        [emgfc_pkg::TIME_W-1:0]        timestamp;
   modport source (output valid, raw_sample, timestamp, input ready);
   modport sink (input valid, raw_sample, timestamp, output ready);
endinterface

interface emgfc_rsp_if;
   logic                                       valid;
   logic                                       ready;
   logic        [emgfc_pkg::TIME_W-1:0]        time_out;
   logic signed [emgfc_pkg::CENT_W-1:0]        centered_sample;
   logic signed [emgfc_pkg::SAMPLE_BITS-1:0]   filtered_sample;
   logic        [emgfc_pkg::SAMPLE_BITS-1:0]   rms_level;
   modport source (output valid, time_out, centered_sample, filtered_sample, rms_level,
                   input ready);
   modport sink (input valid, time_out, centered_sample, filtered_sample, rms_level,
                 output ready);
endinterface

interface emgfc_csr_if;
   logic                                       valid;
   logic                                       ready;
   logic signed [emgfc_pkg::SAMPLE_BITS-1:0]   dc_offset;
   modport source (output valid, dc_offset, input ready);
   modport sink (input valid, dc_offset, output ready);
endinterface

[rtl/core/emgfc_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module emgfc_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

[rtl/core/emgfc_datapath.sv]
// Datapath: shared multiplier, biquad history, window store, divider and root unit.
module emgfc_datapath (
   input  logic                                     clock,
   input  logic                                     reset,
   input  emgfc_pkg::cmd_type                       cmd,
   input  logic                                     csr_we,
   input  logic signed [emgfc_pkg::SAMPLE_BITS-1:0] csr_data,
   input  logic signed [emgfc_pkg::SAMPLE_BITS-1:0] raw_sample,
   input  logic        [emgfc_pkg::TIME_W-1:0]      timestamp,
   output logic        [emgfc_pkg::TIME_W-1:0]      time_out,
   output logic signed [emgfc_pkg::CENT_W-1:0]      centered_sample,
   output logic signed [emgfc_pkg::SAMPLE_BITS-1:0] filtered_sample,
   output logic        [emgfc_pkg::SAMPLE_BITS-1:0] rms_level
);

   localparam int SB = emgfc_pkg::SAMPLE_BITS;
   localparam int SW = emgfc_pkg::SIG_W;
   localparam int AW = emgfc_pkg::ACC_W;
   localparam int MW = emgfc_pkg::MUL_W;
   localparam int CW = emgfc_pkg::COEF_W;
   localparam int YW = SW + 1;
   localparam logic signed [AW-1:0] ACC_HALF = AW'(64'sd1 <<< (emgfc_pkg::COEF_FRAC_BITS - 1));
   localparam logic signed [AW-1:0] ACC_SMAX = AW'((64'sd1 <<< (SW - 1)) - 1);
   localparam logic signed [AW-1:0] ACC_SMIN = AW'(-(64'sd1 <<< (SW - 1)));
   localparam logic signed [YW-1:0] Y_HALF = YW'(1 <<< (emgfc_pkg::SIG_FRAC - 1));
   localparam logic signed [YW-1:0] Y_SMAX = YW'((1 <<< (SB - 1)) - 1);
   localparam logic signed [YW-1:0] Y_SMIN = YW'(-(1 <<< (SB - 1)));

   logic signed [SW-1:0] hist_ff [emgfc_pkg::NHIST];
   logic signed [SW-1:0] hist_in [emgfc_pkg::NHIST];
   logic signed [SW-1:0] x_ff, x_in;
   logic signed [AW-1:0] acc_ff, acc_in;
   logic signed [MW-1:0] prod_ff, prod_in;
   logic signed [SB-1:0] dc_ff, dc_in;
   logic [emgfc_pkg::TIME_W-1:0] ts_ff, ts_in;
   logic signed [emgfc_pkg::CENT_W-1:0] cent_ff, cent_in;
   logic signed [SB-1:0] filt_ff, filt_in;
   logic [emgfc_pkg::SUM_W-1:0] sum_ff, sum_in;
   logic [emgfc_pkg::PTR_W-1:0] wptr_ff, wptr_in;
   logic [emgfc_pkg::CNT_W-1:0] cnt_ff, cnt_in;
   logic [emgfc_pkg::SUM_W-1:0] dq_ff, dq_in;
   logic [emgfc_pkg::CNT_W-1:0] drem_ff, drem_in;
   logic [emgfc_pkg::ROOT_W-1:0] root_ff, root_in;
   logic [emgfc_pkg::SREM_W-1:0] srem_ff, srem_in;
   logic [emgfc_pkg::TIME_W-1:0] otime_ff, otime_in;
   logic signed [emgfc_pkg::CENT_W-1:0] ocent_ff, ocent_in;
   logic signed [SB-1:0] ofilt_ff, ofilt_in;
   logic [SB-1:0] orms_ff, orms_in;

   logic signed [CW-1:0] mul_a;
   logic signed [SW-1:0] mul_b;
   logic [emgfc_pkg::IDX_W-1:0] cidx, hidx;
   logic [emgfc_pkg::STEP_W-1:0] acc_tap;
   logic signed [AW-1:0] acc_term, stage_sh;
   logic signed [SW-1:0] stage_y;
   logic signed [YW-1:0] filt_sh;
   logic signed [SB-1:0] old_sample;
   logic full;
   logic ram_we;
   logic [emgfc_pkg::CNT_W:0] drem_sh;
   logic div_ge;
   logic [emgfc_pkg::SREM_W-1:0] srem_sh, strial;
   logic sqrt_ge;

   emgfc_ram #(.WIDTH(SB), .DEPTH(emgfc_pkg::WINDOW)) u_window (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (wptr_ff),
      .wr_data (filt_ff),
      .rd_addr (wptr_ff),
      .rd_data (old_sample)
   );

   assign full    = (cnt_ff == emgfc_pkg::CNT_W'(emgfc_pkg::WINDOW));
   assign ram_we  = (cmd.op == emgfc_pkg::OP_UPD);
   assign cidx    = emgfc_pkg::IDX_W'(cmd.stage) * emgfc_pkg::IDX_W'(emgfc_pkg::NTAPS)
                  + emgfc_pkg::IDX_W'(cmd.step);
   assign hidx    = {cmd.stage, 2'b00} + emgfc_pkg::IDX_W'(cmd.step) - emgfc_pkg::IDX_W'(1);
   assign acc_tap = cmd.step - emgfc_pkg::STEP_W'(1);

   // Stage rounding: add half an LSB, floor, then clamp to the signal range.
   assign stage_sh = (acc_ff + ACC_HALF) >>> emgfc_pkg::COEF_FRAC_BITS;
   always_comb begin
      if (stage_sh > ACC_SMAX) begin
         stage_y = SW'(ACC_SMAX);
      end else if (stage_sh < ACC_SMIN) begin
         stage_y = SW'(ACC_SMIN);
      end else begin
         stage_y = SW'(stage_sh);
      end
   end

   assign filt_sh = (YW'(x_ff) + Y_HALF) >>> emgfc_pkg::SIG_FRAC;

   assign drem_sh = {drem_ff, dq_ff[emgfc_pkg::SUM_W-1]};
   assign div_ge  = (drem_sh >= {1'b0, cnt_ff});
   assign srem_sh = {srem_ff[emgfc_pkg::SREM_W-3:0], dq_ff[emgfc_pkg::SUM_W-1 -: 2]};
   assign strial  = emgfc_pkg::SREM_W'({root_ff, 2'b01});
   assign sqrt_ge = (srem_sh >= strial);

   // Multiplier operand selection.
   always_comb begin
      mul_a = CW'(filt_ff);
      mul_b = SW'(filt_ff);
      if (cmd.op == emgfc_pkg::OP_MAC) begin
         mul_a = emgfc_pkg::COEF_TABLE[cidx];
         mul_b = (cmd.step == '0) ? x_ff : hist_ff[hidx];
      end else if (cmd.op == emgfc_pkg::OP_FILT) begin
         mul_a = CW'(old_sample);
         mul_b = SW'(old_sample);
      end
   end
   assign prod_in = MW'(mul_a) * MW'(mul_b);

   assign acc_term = (acc_tap >= emgfc_pkg::STEP_W'(3)) ? -AW'(prod_ff) : AW'(prod_ff);

   always_comb begin
      hist_in  = hist_ff;
      x_in     = x_ff;
      acc_in   = acc_ff;
      dc_in    = csr_we ? csr_data : dc_ff;
      ts_in    = ts_ff;
      cent_in  = cent_ff;
      filt_in  = filt_ff;
      sum_in   = sum_ff;
      wptr_in  = wptr_ff;
      cnt_in   = cnt_ff;
      dq_in    = dq_ff;
      drem_in  = drem_ff;
      root_in  = root_ff;
      srem_in  = srem_ff;
      otime_in = otime_ff;
      ocent_in = ocent_ff;
      ofilt_in = ofilt_ff;
      orms_in  = orms_ff;
      case (cmd.op)
         emgfc_pkg::OP_LOAD: begin
            ts_in   = timestamp;
            cent_in = emgfc_pkg::CENT_W'(raw_sample) - emgfc_pkg::CENT_W'(dc_ff);
            x_in    = SW'(cent_in) <<< emgfc_pkg::SIG_FRAC;
         end
         emgfc_pkg::OP_MAC: begin
            if (cmd.step == '0) begin
               acc_in = '0;
            end else begin
               acc_in = acc_ff + acc_term;
            end
         end
         emgfc_pkg::OP_STAGE: begin
            for (int i = 0; i < emgfc_pkg::NSTAGES; i++) begin
               if (cmd.stage == emgfc_pkg::STAGE_W'(i)) begin
                  hist_in[i*4+1] = hist_ff[i*4];
                  hist_in[i*4]   = x_ff;
                  hist_in[i*4+3] = hist_ff[i*4+2];
                  hist_in[i*4+2] = stage_y;
               end
            end
            x_in = stage_y;
         end
         emgfc_pkg::OP_FILT: begin
            if (filt_sh > Y_SMAX) begin
               filt_in = SB'(Y_SMAX);
            end else if (filt_sh < Y_SMIN) begin
               filt_in = SB'(Y_SMIN);
            end else begin
               filt_in = SB'(filt_sh);
            end
         end
         emgfc_pkg::OP_SQN: begin
            if (full) begin
               sum_in = sum_ff - prod_ff[emgfc_pkg::SUM_W-1:0];
            end
         end
         emgfc_pkg::OP_UPD: begin
            sum_in  = sum_ff + prod_ff[emgfc_pkg::SUM_W-1:0];
            wptr_in = (wptr_ff == emgfc_pkg::PTR_W'(emgfc_pkg::WINDOW - 1)) ? '0
                    : wptr_ff + emgfc_pkg::PTR_W'(1);
            cnt_in  = full ? cnt_ff : cnt_ff + emgfc_pkg::CNT_W'(1);
            dq_in   = sum_in;
            drem_in = '0;
            root_in = '0;
            srem_in = '0;
         end
         emgfc_pkg::OP_DIV: begin
            drem_in = div_ge ? emgfc_pkg::CNT_W'(drem_sh - {1'b0, cnt_ff})
                             : drem_sh[emgfc_pkg::CNT_W-1:0];
            dq_in   = {dq_ff[emgfc_pkg::SUM_W-2:0], div_ge};
         end
         emgfc_pkg::OP_SQRT: begin
            srem_in = sqrt_ge ? srem_sh - strial : srem_sh;
            root_in = {root_ff[emgfc_pkg::ROOT_W-2:0], sqrt_ge};
            dq_in   = {dq_ff[emgfc_pkg::SUM_W-3:0], 2'b00};
         end
         emgfc_pkg::OP_OUT: begin
            otime_in = ts_ff;
            ocent_in = cent_ff;
            ofilt_in = filt_ff;
            orms_in  = root_ff[SB-1:0];
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hist_ff <= '{default: '0};
         dc_ff   <= '0;
         sum_ff  <= '0;
         wptr_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         hist_ff <= hist_in;
         dc_ff   <= dc_in;
         sum_ff  <= sum_in;
         wptr_ff <= wptr_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff     <= x_in;
      acc_ff   <= acc_in;
      prod_ff  <= prod_in;
      ts_ff    <= ts_in;
      cent_ff  <= cent_in;
      filt_ff  <= filt_in;
      dq_ff    <= dq_in;
      drem_ff  <= drem_in;
      root_ff  <= root_in;
      srem_ff  <= srem_in;
      otime_ff <= otime_in;
      ocent_ff <= ocent_in;
      ofilt_ff <= ofilt_in;
      orms_ff  <= orms_in;
   end

   assign time_out        = otime_ff;
   assign centered_sample = ocent_ff;
   assign filtered_sample = ofilt_ff;
   assign rms_level       = orms_ff;

endmodule

[rtl/core/emgfc_ctrl.sv]
// Controller: sequences load, filter taps, window update, divide, root and output.
module emgfc_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               rsp_ready,
   output logic               rsp_valid,
   output emgfc_pkg::cmd_type cmd
);

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_MAC   = 4'd1;
   localparam logic [3:0] ST_STAGE = 4'd2;
   localparam logic [3:0] ST_FILT  = 4'd3;
   localparam logic [3:0] ST_SQN   = 4'd4;
   localparam logic [3:0] ST_UPD   = 4'd5;
   localparam logic [3:0] ST_DIV   = 4'd6;
   localparam logic [3:0] ST_SQRT  = 4'd7;
   localparam logic [3:0] ST_DONE  = 4'd8;

   logic [3:0] state_ff, state_in;
   logic [emgfc_pkg::STAGE_W-1:0] stage_ff, stage_in;
   logic [emgfc_pkg::STEP_W-1:0] step_ff, step_in;
   logic [emgfc_pkg::ITER_W-1:0] iter_ff, iter_in;
   logic ovalid_ff, ovalid_in;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = ovalid_ff;

   always_comb begin
      state_in  = state_ff;
      stage_in  = stage_ff;
      step_in   = step_ff;
      iter_in   = iter_ff;
      ovalid_in = ovalid_ff && !rsp_ready;
      cmd.op    = emgfc_pkg::OP_NONE;
      cmd.stage = stage_ff;
      cmd.step  = step_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.op   = emgfc_pkg::OP_LOAD;
               stage_in = '0;
               step_in  = '0;
               state_in = ST_MAC;
            end
         end
         ST_MAC: begin
            cmd.op = emgfc_pkg::OP_MAC;
            if (step_ff == emgfc_pkg::STEP_W'(emgfc_pkg::NTAPS)) begin
               state_in = ST_STAGE;
            end else begin
               step_in = step_ff + emgfc_pkg::STEP_W'(1);
            end
         end
         ST_STAGE: begin
            cmd.op = emgfc_pkg::OP_STAGE;
            if (stage_ff == emgfc_pkg::STAGE_W'(emgfc_pkg::NSTAGES - 1)) begin
               state_in = ST_FILT;
            end else begin
               stage_in = stage_ff + emgfc_pkg::STAGE_W'(1);
               step_in  = '0;
               state_in = ST_MAC;
            end
         end
         ST_FILT: begin
            cmd.op   = emgfc_pkg::OP_FILT;
            state_in = ST_SQN;
         end
         ST_SQN: begin
            cmd.op   = emgfc_pkg::OP_SQN;
            state_in = ST_UPD;
         end
         ST_UPD: begin
            cmd.op   = emgfc_pkg::OP_UPD;
            iter_in  = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            cmd.op = emgfc_pkg::OP_DIV;
            if (iter_ff == emgfc_pkg::ITER_W'(emgfc_pkg::SUM_W - 1)) begin
               iter_in  = '0;
               state_in = ST_SQRT;
            end else begin
               iter_in = iter_ff + emgfc_pkg::ITER_W'(1);
            end
         end
         ST_SQRT: begin
            cmd.op = emgfc_pkg::OP_SQRT;
            if (iter_ff == emgfc_pkg::ITER_W'(emgfc_pkg::ROOT_W - 1)) begin
               state_in = ST_DONE;
            end else begin
               iter_in = iter_ff + emgfc_pkg::ITER_W'(1);
            end
         end
         ST_DONE: begin
            if (!ovalid_ff || rsp_ready) begin
               cmd.op    = emgfc_pkg::OP_OUT;
               ovalid_in = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         stage_ff  <= '0;
         step_ff   <= '0;
         iter_ff   <= '0;
         ovalid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         stage_ff  <= stage_in;
         step_ff   <= step_in;
         iter_ff   <= iter_in;
         ovalid_ff <= ovalid_in;
      end
   end

endmodule

[rtl/core/emg_filter_chain_rms_envelope_top.sv]
// EMG filter chain with moving RMS envelope: top level.
// Each request beat carries one raw EMG sample and its timestamp; the block subtracts the
// dc_offset register, runs the centered value through a 20 Hz highpass, a 450 Hz lowpass
// and a 50 Hz notch biquad in cascade, saturates the result to 16 bits, and returns one
// response beat with the timestamp, the centered and filtered samples and the RMS envelope
// over the last 500 filtered samples (divided by the samples seen so far until the window
// has filled). One item is processed at a time. After the request beat is taken, the
// fifteen filter products run on the single shared multiplier (six multiply-accumulate
// steps and one rounding step per stage), followed by the window update, the bit-serial
// divider, the bit-serial square root and the load of the output register, which waits
// until the previous response has been taken. A finished result sits in an output
// register, so the next request beat is taken while the previous response still waits. The
// window store needs no clearing pass after reset, because an entry is only read back once
// the window has filled. The offset register may be written at any time the block is idle;
// its port is always ready.
module emg_filter_chain_rms_envelope_top (
   input logic         clock,
   input logic         reset,
   emgfc_req_if.sink   req_bus,
   emgfc_rsp_if.source rsp_bus,
   emgfc_csr_if.sink   csr_bus
);

   emgfc_pkg::cmd_type cmd;

   // The offset register takes a write in any cycle.
   assign csr_bus.ready = 1'b1;

   emgfc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_ready (rsp_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .cmd       (cmd)
   );

   emgfc_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .csr_we          (csr_bus.valid),
      .csr_data        (csr_bus.dc_offset),
      .raw_sample      (req_bus.raw_sample),
      .timestamp       (req_bus.timestamp),
      .time_out        (rsp_bus.time_out),
      .centered_sample (rsp_bus.centered_sample),
      .filtered_sample (rsp_bus.filtered_sample),
      .rms_level       (rsp_bus.rms_level)
   );

endmodule

[rtl/core/emgfc_checker.sv]
// Port-level checker for the EMG filter chain and its bind to the top level.
module emgfc_checker (
   input logic                                     clock,
   input logic                                     reset,
   input logic                                     req_valid,
   input logic                                     req_ready,
   input logic                                     rsp_valid,
   input logic                                     rsp_ready,
   input logic        [emgfc_pkg::TIME_W-1:0]      time_out,
   input logic        [emgfc_pkg::SAMPLE_BITS-1:0] rms_level
);

   // A response beat holds until it is taken.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped before it was taken");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(time_out) && $stable(rms_level))
      else $error("stalled response payload changed");

   // Only one item is in flight, so the request side closes right after a beat.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while an item is in progress");

   // A result never appears in the cycle right after its request.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !$rose(rsp_valid))
      else $error("response appeared too early");

   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind emg_filter_chain_rms_envelope_top emgfc_checker u_emgfc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_bus.valid),
   .req_ready (req_bus.ready),
   .rsp_valid (rsp_bus.valid),
   .rsp_ready (rsp_bus.ready),
   .time_out  (rsp_bus.time_out),
   .rms_level (rsp_bus.rms_level)
);

[tb/tb_emg_filter_chain_rms_envelope_top.sv]
// Self-checking testbench for the EMG filter chain with moving RMS envelope.
module tb_emg_filter_chain_rms_envelope_top;

   // Clock and the single synchronous reset at the start of the run.
   logic clock;
   logic reset;

   initial clock = 1'b0;
   always #10 clock = ~clock;

   emgfc_req_if req_bus ();
   emgfc_rsp_if rsp_bus ();
   emgfc_csr_if csr_bus ();

   emg_filter_chain_rms_envelope_top i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus.sink),
      .rsp_bus (rsp_bus.source),
      .csr_bus (csr_bus.sink)
   );

   // One expected response beat.
   typedef struct {
      logic [emgfc_pkg::TIME_W-1:0]             time_out;
      logic signed [emgfc_pkg::CENT_W-1:0]      centered_sample;
      logic signed [emgfc_pkg::SAMPLE_BITS-1:0] filtered_sample;
      logic [emgfc_pkg::SAMPLE_BITS-1:0]        rms_level;
   } envelope_result_type;

   // Directed stimulus row. The typed-in fields are compared against the
   // prediction, so a mistake in either one shows up as a failure.
   typedef struct {
      logic signed [emgfc_pkg::SAMPLE_BITS-1:0] raw;
      logic [emgfc_pkg::TIME_W-1:0]             stamp;
      bit                                       has_typed;
      logic signed [emgfc_pkg::CENT_W-1:0]      typed_centered;
      logic signed [emgfc_pkg::SAMPLE_BITS-1:0] typed_filtered;
      logic [emgfc_pkg::SAMPLE_BITS-1:0]        typed_rms;
   } sample_row_type;

   localparam longint SIG_HI = 64'sd268435455;
   localparam longint SIG_LO = -64'sd268435456;
   localparam int     WATCHDOG_LIMIT = 20000;
   localparam int     DRAIN_CYCLES = 200;

   // Filter and window state of the predictor.
   longint                 offset_value;
   longint                 coef_q_tab [emgfc_pkg::NCOEF];
   longint                 stage_hist [emgfc_pkg::NHIST];
   longint                 window_store [emgfc_pkg::WINDOW];
   longint unsigned        square_sum;
   int                     write_slot;
   int                     filled_count;

   envelope_result_type    pending_results [$];
   int                     error_count;
   int                     accepted_samples;
   int                     checked_results;
   int                     idle_cycles;
   bit                     stimulus_done;

   // Floor division by a power of two, arithmetic shift on signed values.
   function automatic longint floor_div_pow2(longint a, int sh);
      return a >>> sh;
   endfunction

   function automatic longint clamp(longint v, longint lo, longint hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned root;
      longint unsigned bitpos;
      root = 0;
      bitpos = 64'd1 << 62;
      while (bitpos > v) bitpos >>= 2;
      while (bitpos != 0) begin
         if (v >= root + bitpos) begin
            v -= root + bitpos;
            root = (root >> 1) + bitpos;
         end else begin
            root >>= 1;
         end
         bitpos >>= 2;
      end
      return root;
   endfunction

   task automatic reset_filter_state();
      longint seven_dec [emgfc_pkg::NCOEF];
      longint mag;
      longint q;
      seven_dec = '{64'sd9149691, -64'sd18299383, 64'sd9149691, -64'sd18226949, 64'sd8371817,
                    64'sd8005924, 64'sd16011848, 64'sd8005924, 64'sd15610181, 64'sd6413515,
                    64'sd9947912, -64'sd18922054, 64'sd9947912, -64'sd18922054,
                    64'sd9895825};
      offset_value = 0;
      for (int i = 0; i < emgfc_pkg::NCOEF; i++) begin
         mag = (seven_dec[i] < 0) ? -seven_dec[i] : seven_dec[i];
         q = (mag * (64'sd1 << emgfc_pkg::COEF_FRAC_BITS) + 64'sd5000000) / 64'sd10000000;
         coef_q_tab[i] = (seven_dec[i] < 0) ? -q : q;
      end
      foreach (stage_hist[i]) stage_hist[i] = 0;
      foreach (window_store[i]) window_store[i] = 0;
      square_sum = 0;
      write_slot = 0;
      filled_count = 0;
   endtask

   // Runs one sample through the cascade and the RMS window.
   function automatic envelope_result_type predict_envelope(
      logic signed [emgfc_pkg::SAMPLE_BITS-1:0] raw,
      logic [emgfc_pkg::TIME_W-1:0] stamp);
      envelope_result_type r;
      longint centered;
      longint sig;
      longint acc;
      longint filt;
      longint smax;
      int     c;
      int     h;
      smax = (64'sd1 <<< (emgfc_pkg::SAMPLE_BITS - 1)) - 1;
      centered = longint'(raw) - offset_value;
      sig = clamp(centered * 256, SIG_LO, SIG_HI);
      for (int k = 0; k < emgfc_pkg::NSTAGES; k++) begin
         c = k * emgfc_pkg::NTAPS;
         h = k * 4;
         acc = coef_q_tab[c] * sig + coef_q_tab[c+1] * stage_hist[h]
               + coef_q_tab[c+2] * stage_hist[h+1] - coef_q_tab[c+3] * stage_hist[h+2]
               - coef_q_tab[c+4] * stage_hist[h+3];
         acc = clamp(floor_div_pow2(acc + (64'sd1 <<< (emgfc_pkg::COEF_FRAC_BITS - 1)),
                                    emgfc_pkg::COEF_FRAC_BITS),
                     SIG_LO, SIG_HI);
         stage_hist[h+1] = stage_hist[h];
         stage_hist[h]   = sig;
         stage_hist[h+3] = stage_hist[h+2];
         stage_hist[h+2] = acc;
         sig = acc;
      end
      filt = clamp(floor_div_pow2(sig + 128, emgfc_pkg::SIG_FRAC), -smax - 1, smax);
      // Once the window is full the oldest square drops out as the new one enters.
      if (filled_count >= emgfc_pkg::WINDOW)
         square_sum -= longint'(window_store[write_slot] * window_store[write_slot]);
      else
         filled_count++;
      window_store[write_slot] = filt;
      square_sum += longint'(filt * filt);
      write_slot = (write_slot + 1) % emgfc_pkg::WINDOW;
      r.time_out = stamp;
      r.centered_sample = centered[emgfc_pkg::CENT_W-1:0];
      r.filtered_sample = filt[emgfc_pkg::SAMPLE_BITS-1:0];
      r.rms_level = emgfc_pkg::SAMPLE_BITS'(int_sqrt(square_sum / filled_count));
      return r;
   endfunction

   // Input defaults; everything changes at the falling edge.
   initial begin
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.raw_sample = '0;
      req_bus.timestamp = '0;
      csr_bus.valid = 1'b0;
      csr_bus.dc_offset = '0;
      rsp_bus.ready = 1'b0;
   end

   // Writes the offset register with the block idle and mirrors it in the predictor.
   task automatic write_dc_offset(logic signed [emgfc_pkg::SAMPLE_BITS-1:0] value);
      @(negedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.dc_offset <= value;
      do @(posedge clock); while (!csr_bus.ready);
      offset_value = longint'(value);
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   // Sender bursts: valid stays high across a burst and may drop for a random gap between bursts.
   int burst_left;

   task automatic send_sample(logic signed [emgfc_pkg::SAMPLE_BITS-1:0] raw,
                              logic [emgfc_pkg::TIME_W-1:0] stamp);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 150);
         if (gap != 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_bus.valid <= 1'b1;
      req_bus.raw_sample <= raw;
      req_bus.timestamp <= stamp;
      do @(posedge clock); while (!req_bus.ready);
      pending_results.push_back(predict_envelope(raw, stamp));
      accepted_samples++;
      @(negedge clock);
   endtask

   // Waits until every prediction has been answered, then lets the block settle.
   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // Receiver stall pattern: alternates between long ready stretches and
   // phases of random back-pressure, light and heavy in turn.
   int stall_phase;
   always @(negedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         stall_phase <= 0;
      end else begin
         stall_phase <= stall_phase + 1;
         if (stall_phase[9])
            rsp_bus.ready <= 1'b1;
         else if (stall_phase[6])
            rsp_bus.ready <= ($urandom_range(0, 7) == 0);
         else
            rsp_bus.ready <= ($urandom_range(0, 2) != 0);
      end
   end

   // Response checker, compares each beat against the oldest prediction.
   always @(posedge clock) begin
      envelope_result_type exp_r;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected response beat, time_out %0d", $time, rsp_bus.time_out);
            error_count++;
         end else begin
            exp_r = pending_results.pop_front();
            checked_results++;
            if (rsp_bus.time_out !== exp_r.time_out) begin
               $display("%0t: time_out expected %0d actual %0d", $time, exp_r.time_out,
                        rsp_bus.time_out);
               error_count++;
            end
            if (rsp_bus.centered_sample !== exp_r.centered_sample) begin
               $display("%0t: centered_sample expected %0d actual %0d", $time,
                        exp_r.centered_sample, rsp_bus.centered_sample);
               error_count++;
            end
            if (rsp_bus.filtered_sample !== exp_r.filtered_sample) begin
               $display("%0t: filtered_sample expected %0d actual %0d", $time,
                        exp_r.filtered_sample, rsp_bus.filtered_sample);
               error_count++;
            end
            if (rsp_bus.rms_level !== exp_r.rms_level) begin
               $display("%0t: rms_level expected %0d actual %0d", $time,
                        exp_r.rms_level, rsp_bus.rms_level);
               error_count++;
            end
         end
      end
   end

   // Watchdog: counts cycles in which no beat moves on any channel.
   always @(posedge clock) begin
      if (reset || stimulus_done ||
          (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          (csr_bus.valid && csr_bus.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: watchdog expired, %0d results outstanding", $time,
                  pending_results.size());
         $display("Regression FAIL");
         $finish;
      end
   end

   // Directed rows: extremes of the raw sample and timestamp, and the offset
   // extremes. The very first beat after reset has a typed-in answer: a zero
   // sample with zero offset yields all-zero outputs.
   sample_row_type directed_rows [9] = '{
      '{16'sd0,      32'd0,          1'b1, 17'sd0, 16'sd0, 16'd0},
      '{16'sh7fff,   32'hffffffff,   1'b0, '0, '0, '0},
      '{16'sh8000,   32'h00000001,   1'b0, '0, '0, '0},
      '{16'sh7fff,   32'h80000000,   1'b0, '0, '0, '0},
      '{16'sh8000,   32'h7fffffff,   1'b0, '0, '0, '0},
      '{16'sh5555,   32'haaaaaaaa,   1'b0, '0, '0, '0},
      '{16'shaaaa,   32'h55555555,   1'b0, '0, '0, '0},
      '{-16'sd1,     32'd7,          1'b0, '0, '0, '0},
      '{16'sd1,      32'd8,          1'b0, '0, '0, '0}
   };

   initial begin
      logic signed [emgfc_pkg::SAMPLE_BITS-1:0] offsets [4];
      logic signed [emgfc_pkg::SAMPLE_BITS-1:0] raw;
      logic [emgfc_pkg::TIME_W-1:0]             stamp;
      envelope_result_type                      first_expect;
      int                                       mode;
      offsets = '{16'sh7fff, 16'sh8000, 16'sd1200, -16'sd300};
      error_count = 0;
      accepted_samples = 0;
      checked_results = 0;
      stimulus_done = 1'b0;
      burst_left = 0;
      reset_filter_state();
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part with zero offset, then each offset extreme over the
      // same rows so the centered sample reaches both ends of its range.
      for (int pass = 0; pass < 3; pass++) begin
         if (pass > 0) write_dc_offset(offsets[pass - 1]);
         foreach (directed_rows[i]) begin
            if (pass == 0 && directed_rows[i].has_typed) begin
               first_expect.centered_sample = directed_rows[i].typed_centered;
               first_expect.filtered_sample = directed_rows[i].typed_filtered;
               first_expect.rms_level = directed_rows[i].typed_rms;
               send_sample(directed_rows[i].raw, directed_rows[i].stamp);
               if (pending_results[$].centered_sample !== first_expect.centered_sample ||
                   pending_results[$].filtered_sample !== first_expect.filtered_sample ||
                   pending_results[$].rms_level !== first_expect.rms_level) begin
                  $display("%0t: predictor disagrees with typed result, expected %0d actual %0d",
                           $time, first_expect.filtered_sample,
                           pending_results[$].filtered_sample);
                  error_count++;
               end
            end else begin
               send_sample(directed_rows[i].raw, directed_rows[i].stamp);
            end
         end
         wait_drained();
      end

      // Random part, in phases with different offsets. The window fills after
      // 500 samples, so the sliding behavior is reached in the last phase.
      for (int phase = 0; phase < 4; phase++) begin
         write_dc_offset(phase == 3 ? 16'sd0 : offsets[phase + 1 < 4 ? phase + 1 : 3]);
         for (int n = 0; n < 130; n++) begin
            mode = $urandom_range(0, 9);
            if (mode < 5)
               raw = emgfc_pkg::SAMPLE_BITS'($urandom_range(0, 4000) - 2000);
            else if (mode < 8)
               raw = emgfc_pkg::SAMPLE_BITS'($urandom);
            else
               raw = ($urandom_range(0, 1) != 0) ? 16'sh7fff : 16'sh8000;
            stamp = $urandom;
            send_sample(raw, stamp);
         end
         wait_drained();
      end

      stimulus_done = 1'b1;
      $display("Covered %0d samples across directed extremes and four random offset phases,",
               accepted_samples);
      $display("%0d responses checked, window filled and sliding.", checked_results);
      if (error_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
